@@ rtl/kshs_pkg.sv @@
`default_nettype none

package kshs_pkg;

   // Fixed field widths of the key set scorer.
   localparam int KEY_BITS         = 128;
   localparam int HALF_BITS        = 64;
   localparam int HALF_CNT_W       = 7;
   localparam int DIST_W           = 8;
   localparam int SUM_W            = 24;
   localparam int PAIRS_W          = 17;
   localparam int MAX_KEYS_DEFAULT = 512;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_REJECT_BELOW = 1'b0;

   // Distance seeded into the running minimum before the first pair.
   localparam logic [DIST_W-1:0] MIN_SEED = DIST_W'(KEY_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PIVOT,
      ST_WALK,
      ST_DRAIN
   } state_type;

   // Population count of one 64-bit half, formed as eight byte counts added together.
   function automatic logic [HALF_CNT_W-1:0] popcount64(input logic [HALF_BITS-1:0] v);
      logic [HALF_CNT_W-1:0] total;
      logic [3:0]            byte_cnt;
      total = '0;
      for (int b = 0; b < 8; b++) begin
         byte_cnt = '0;
         for (int k = 0; k < 8; k++) begin
            byte_cnt = byte_cnt + 4'(v[8*b+k]);
         end
         total = total + HALF_CNT_W'(byte_cnt);
      end
      return total;
   endfunction

endpackage

`default_nettype wire

@@ rtl/key_set_pairwise_hamming_scorer.sv @@
`default_nettype none

// Pairwise Hamming distance scorer for a set of 128-bit keys.
//
// Input channel: a transaction is accepted when start is high and busy is low. Each
// transaction carries one key (req_key_high, req_key_low) that is written into the key
// memory; a key that arrives while MAX_KEYS keys are held is dropped and flagged.
// A transaction with req_last_key set closes the set and starts the pair walk.
// Keys that do not close a set are taken one per cycle and busy stays low.
//
// Pair walk: every pair (i, j) with i < j is visited in row order. One memory read
// port and one popcount/accumulate unit are reused for every pair: each row first
// fetches its pivot key (ST_PIVOT), then reads one partner key at a time (ST_WALK),
// and after the last row the pipeline drains (ST_DRAIN), so the memory read port
// sets the rate. busy stays high for the whole walk.
// The walk stops early once the running minimum falls below reject_below.
//
// Result channel: one transaction per set, shown for exactly one cycle with rsp_valid.
// The receiver cannot stall it. The key count and overflow flag then clear.
// Reset clears the control state and reject_below; the key memory is not cleared
// because only keys written in the current set are ever read.
module key_set_pairwise_hamming_scorer #(
   parameter int MAX_KEYS = kshs_pkg::MAX_KEYS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [kshs_pkg::HALF_BITS-1:0]   req_key_high,
   input  wire logic [kshs_pkg::HALF_BITS-1:0]   req_key_low,
   input  wire logic                             req_last_key,
   // Result channel
   output logic                                  rsp_valid,
   output logic [kshs_pkg::DIST_W-1:0]           rsp_min_distance,
   output logic [kshs_pkg::SUM_W-1:0]            rsp_distance_sum,
   output logic [kshs_pkg::PAIRS_W-1:0]          rsp_pairs_examined,
   output logic                                  rsp_stopped_early,
   output logic                                  rsp_set_overflow,
   // Configuration port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [kshs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [kshs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [kshs_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   // Address width indexes the memory; count width can also hold MAX_KEYS itself.
   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [kshs_pkg::DIST_W-1:0] reject_below_ff;
   logic                        csr_write;
   logic                        csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == kshs_pkg::REG_REJECT_BELOW) && (paddr[1:0] == 2'b00);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_below_ff <= '0;
      end else if (csr_write && (paddr[2] == kshs_pkg::REG_REJECT_BELOW)) begin
         reject_below_ff <= pwdata[kshs_pkg::DIST_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = kshs_pkg::CSR_DATA_W'(reject_below_ff);
      end
   end

   // ------------------------------------------------------------------
   // Key loading
   // ------------------------------------------------------------------
   kshs_pkg::state_type state_ff, state_in;

   logic          accept;
   logic          room;
   logic [CW-1:0] keys_loaded_ff;
   logic          overflow_ff;
   logic          emit;

   assign busy   = (state_ff != kshs_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign room   = (keys_loaded_ff < CW'(MAX_KEYS));

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_loaded_ff <= '0;
         overflow_ff    <= 1'b0;
      end else if (emit) begin
         keys_loaded_ff <= '0;
         overflow_ff    <= 1'b0;
      end else if (accept) begin
         if (room) begin
            keys_loaded_ff <= keys_loaded_ff + CW'(1);
         end else begin
            overflow_ff <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Key memory: one write port for loading, one registered read port for the walk
   // ------------------------------------------------------------------
   logic [kshs_pkg::KEY_BITS-1:0] key_mem [MAX_KEYS];
   logic [kshs_pkg::KEY_BITS-1:0] mem_q_ff;
   logic [AW-1:0]                 rd_addr;

   always_ff @(posedge clock) begin
      if (accept && room) begin
         key_mem[keys_loaded_ff[AW-1:0]] <= {req_key_high, req_key_low};
      end
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= key_mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Pair walk sequencer
   // ------------------------------------------------------------------
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic          pair_rd_in;
   logic          pivot_rd_in;
   logic          pair_rd_ff;
   logic          pivot_rd_ff;
   logic          cnt_vld_ff;
   logic          stop_ff;
   logic          row_end;
   logic          last_row;
   logic [CW-1:0] count_after;

   // Number of keys the set holds once the closing key is written.
   assign count_after = room ? (keys_loaded_ff + CW'(1)) : keys_loaded_ff;
   assign row_end     = (CW'(j_ff) + CW'(1)) == keys_loaded_ff;
   assign last_row    = (CW'(i_ff) + CW'(2)) == keys_loaded_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= kshs_pkg::ST_IDLE;
         pair_rd_ff  <= 1'b0;
         pivot_rd_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pair_rd_ff  <= pair_rd_in;
         pivot_rd_ff <= pivot_rd_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      rd_addr     = j_ff;
      pair_rd_in  = 1'b0;
      pivot_rd_in = 1'b0;
      emit        = 1'b0;
      case (state_ff)
         kshs_pkg::ST_IDLE: begin
            if (accept && req_last_key) begin
               i_in = '0;
               if (count_after < CW'(2)) begin
                  state_in = kshs_pkg::ST_DRAIN;
               end else begin
                  state_in = kshs_pkg::ST_PIVOT;
               end
            end
         end
         kshs_pkg::ST_PIVOT: begin
            if (stop_ff) begin
               state_in = kshs_pkg::ST_DRAIN;
            end else begin
               rd_addr     = i_ff;
               pivot_rd_in = 1'b1;
               j_in        = i_ff + AW'(1);
               state_in    = kshs_pkg::ST_WALK;
            end
         end
         kshs_pkg::ST_WALK: begin
            if (stop_ff) begin
               state_in = kshs_pkg::ST_DRAIN;
            end else begin
               pair_rd_in = 1'b1;
               if (row_end) begin
                  if (last_row) begin
                     state_in = kshs_pkg::ST_DRAIN;
                  end else begin
                     i_in     = i_ff + AW'(1);
                     state_in = kshs_pkg::ST_PIVOT;
                  end
               end else begin
                  j_in = j_ff + AW'(1);
               end
            end
         end
         kshs_pkg::ST_DRAIN: begin
            if (!pair_rd_ff && !pivot_rd_ff && !cnt_vld_ff) begin
               emit     = 1'b1;
               state_in = kshs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kshs_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Shared distance unit: XOR and half popcounts, then add and accumulate
   // ------------------------------------------------------------------
   logic [kshs_pkg::KEY_BITS-1:0]   pivot_ff;
   logic [kshs_pkg::KEY_BITS-1:0]   diff;
   logic [kshs_pkg::HALF_CNT_W-1:0] cnt_hi_ff;
   logic [kshs_pkg::HALF_CNT_W-1:0] cnt_lo_ff;
   logic [kshs_pkg::DIST_W-1:0]     pair_dist;
   logic [kshs_pkg::DIST_W-1:0]     min_ff;
   logic [kshs_pkg::DIST_W-1:0]     min_in;
   logic [kshs_pkg::SUM_W-1:0]      sum_ff;
   logic [kshs_pkg::PAIRS_W-1:0]    pairs_ff;

   assign diff      = mem_q_ff ^ pivot_ff;
   assign pair_dist = kshs_pkg::DIST_W'(cnt_hi_ff) + kshs_pkg::DIST_W'(cnt_lo_ff);
   assign min_in    = (pair_dist < min_ff) ? pair_dist : min_ff;

   always_ff @(posedge clock) begin
      if (pivot_rd_ff) begin
         pivot_ff <= mem_q_ff;
      end
      cnt_hi_ff <= kshs_pkg::popcount64(diff[kshs_pkg::KEY_BITS-1:kshs_pkg::HALF_BITS]);
      cnt_lo_ff <= kshs_pkg::popcount64(diff[kshs_pkg::HALF_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= 1'b0;
         stop_ff    <= 1'b0;
         min_ff     <= kshs_pkg::MIN_SEED;
         sum_ff     <= '0;
         pairs_ff   <= '0;
      end else begin
         cnt_vld_ff <= pair_rd_ff;
         if (accept && req_last_key) begin
            stop_ff  <= 1'b0;
            min_ff   <= kshs_pkg::MIN_SEED;
            sum_ff   <= '0;
            pairs_ff <= '0;
         end else if (cnt_vld_ff && !stop_ff) begin
            // Pairs still in flight after an early stop are discarded.
            min_ff   <= min_in;
            sum_ff   <= sum_ff + kshs_pkg::SUM_W'(pair_dist);
            pairs_ff <= pairs_ff + kshs_pkg::PAIRS_W'(1);
            stop_ff  <= (min_in < reject_below_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic                         rsp_valid_ff;
   logic [kshs_pkg::DIST_W-1:0]  rsp_min_ff;
   logic [kshs_pkg::SUM_W-1:0]   rsp_sum_ff;
   logic [kshs_pkg::PAIRS_W-1:0] rsp_pairs_ff;
   logic                         rsp_stop_ff;
   logic                         rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
      if (emit) begin
         rsp_min_ff   <= min_ff;
         rsp_sum_ff   <= sum_ff;
         rsp_pairs_ff <= pairs_ff;
         rsp_stop_ff  <= stop_ff;
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_min_distance   = rsp_min_ff;
   assign rsp_distance_sum   = rsp_sum_ff;
   assign rsp_pairs_examined = rsp_pairs_ff;
   assign rsp_stopped_early  = rsp_stop_ff;
   assign rsp_set_overflow   = rsp_ovf_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding walk");

   a_rsp_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result shown for more than one cycle");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kshs_pkg::ST_IDLE) |-> (!pair_rd_ff && !pivot_rd_ff && !cnt_vld_ff))
      else $error("distance pipeline active while idle");

   a_min_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_distance <= kshs_pkg::MIN_SEED))
      else $error("minimum distance above key width");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      keys_loaded_ff <= CW'(MAX_KEYS))
      else $error("key count beyond memory depth");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Field and port widths, taken from the package.
   localparam int KEY_BITS   = kshs_pkg::KEY_BITS;
   localparam int HALF_BITS  = kshs_pkg::HALF_BITS;
   localparam int DIST_W     = kshs_pkg::DIST_W;
   localparam int SUM_W      = kshs_pkg::SUM_W;
   localparam int PAIRS_W    = kshs_pkg::PAIRS_W;
   localparam int CSR_ADDR_W = kshs_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = kshs_pkg::CSR_DATA_W;

   // The key store holds this many keys; the block is built with its default size.
   localparam int KEY_CAP = kshs_pkg::MAX_KEYS_DEFAULT;

   // Byte address of the early-stop threshold register.
   localparam logic [CSR_ADDR_W-1:0] REJECT_BELOW_ADDR =
      CSR_ADDR_W'(4 * int'(kshs_pkg::REG_REJECT_BELOW));

   // Cycles given to the pipeline to drain after the last result before the
   // configuration is touched or the run ends.
   localparam int DRAIN_CYCLES = 16;

   // A full store walks all 512*511/2 pairs plus one pivot fetch per row, all
   // without a single transaction. The watchdog allows several times that walk.
   localparam int STALL_LIMIT = 600000;

   // Keys per random phase, and the number of phases.
   localparam int PHASE_KEYS  = 90;
   localparam int PHASE_COUNT = 6;

   // One scored set as the result channel reports it.
   typedef struct packed {
      bit [DIST_W-1:0]  min_distance;
      bit [SUM_W-1:0]   distance_sum;
      bit [PAIRS_W-1:0] pairs_examined;
      bit               stopped_early;
      bit               set_overflow;
   } set_score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   start        = 1'b0;
   logic                   busy;
   logic [HALF_BITS-1:0]   req_key_high = '0;
   logic [HALF_BITS-1:0]   req_key_low  = '0;
   logic                   req_last_key = 1'b0;

   logic                   rsp_valid;
   logic [DIST_W-1:0]      rsp_min_distance;
   logic [SUM_W-1:0]       rsp_distance_sum;
   logic [PAIRS_W-1:0]     rsp_pairs_examined;
   logic                   rsp_stopped_early;
   logic                   rsp_set_overflow;

   logic                   psel    = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr   = '0;
   logic [CSR_DATA_W-1:0]  pwdata  = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   key_set_pairwise_hamming_scorer dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_key_high       (req_key_high),
      .req_key_low        (req_key_low),
      .req_last_key       (req_last_key),
      .rsp_valid          (rsp_valid),
      .rsp_min_distance   (rsp_min_distance),
      .rsp_distance_sum   (rsp_distance_sum),
      .rsp_pairs_examined (rsp_pairs_examined),
      .rsp_stopped_early  (rsp_stopped_early),
      .rsp_set_overflow   (rsp_set_overflow),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // Scoring state kept on the testbench side. It mirrors what the block holds:
   // the keys of the open set, whether a key of that set was dropped, and the
   // threshold last written to the register.
   bit [KEY_BITS-1:0] held_key [KEY_CAP];
   int unsigned       held_count;
   bit                key_dropped;
   bit [7:0]          stop_threshold;

   // Scores of closed sets that the block still owes, oldest first.
   set_score_type     pending_scores[$];

   // Percentage of transactions that are preceded by an idle gap on the input side.
   int unsigned       idle_pct;

   // Seed key around which clustered keys of the current set are drawn.
   bit [KEY_BITS-1:0] cluster_key;

   int unsigned       keys_sent;
   int unsigned       sets_scored;
   int unsigned       early_stops;
   int unsigned       overflow_sets;
   int unsigned       mismatch_count;
   int unsigned       stall_cycles;

   function automatic void note_mismatch(input string what,
                                         input longint unsigned want,
                                         input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("tb_top: mismatch in %s: expected %0d, got %0d at %0t",
                  what, want, got, $realtime);
      end
   endfunction

   // Takes in one accepted key. A key marked last closes the set: every pair
   // (i, j) with i < j is scored in row order, the walk halts right after the
   // first pair that pulls the minimum under the threshold, and the score is
   // queued for the checker.
   function automatic void take_key(input bit [KEY_BITS-1:0] key, input bit last);
      set_score_type    score;
      int unsigned      best;
      int unsigned      pair_dist;
      bit [SUM_W-1:0]   total;
      bit [PAIRS_W-1:0] count;
      bit               halted;
      if (held_count < KEY_CAP) begin
         held_key[held_count] = key;
         held_count++;
      end else begin
         key_dropped = 1'b1;
      end
      if (!last) begin
         return;
      end
      best   = KEY_BITS;
      total  = '0;
      count  = '0;
      halted = 1'b0;
      for (int i = 0; i < held_count && !halted; i++) begin
         for (int j = i + 1; j < held_count; j++) begin
            pair_dist = $countones(held_key[i] ^ held_key[j]);
            if (pair_dist < best) begin
               best = pair_dist;
            end
            // Both running totals wrap at their port widths.
            total = total + SUM_W'(pair_dist);
            count = count + PAIRS_W'(1);
            if (best < stop_threshold) begin
               halted = 1'b1;
               break;
            end
         end
      end
      score.min_distance   = DIST_W'(best);
      score.distance_sum   = total;
      score.pairs_examined = count;
      score.stopped_early  = halted;
      score.set_overflow   = key_dropped;
      pending_scores.push_back(score);
      held_count  = 0;
      key_dropped = 1'b0;
   endfunction

   // Draws one key. Most keys are either fully random or a few bit flips away
   // from the cluster seed, so that small distances and exact repeats are common
   // enough to trip every threshold; the all-zero and all-one keys and the
   // complement of the seed give the extreme distances.
   function automatic bit [KEY_BITS-1:0] draw_key();
      bit [KEY_BITS-1:0] key;
      int unsigned       pick;
      int unsigned       bit_pos;
      pick = $urandom_range(99);
      if (pick < 35) begin
         key = {$urandom, $urandom, $urandom, $urandom};
      end else if (pick < 75) begin
         key = cluster_key;
         for (int flips = $urandom_range(1, 10); flips > 0; flips--) begin
            bit_pos = $urandom_range(KEY_BITS - 1);
            key[bit_pos] = ~key[bit_pos];
         end
      end else if (pick < 85) begin
         key = cluster_key;
      end else if (pick < 90) begin
         key = '0;
      end else if (pick < 95) begin
         key = '1;
      end else begin
         key = ~cluster_key;
      end
      return key;
   endfunction

   // Result side and watchdog. Outputs are sampled at the rising edge, so the
   // values seen are the ones held during the cycle that the edge closes.
   always @(posedge clock) begin
      set_score_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (psel && penable)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: watchdog expired after %0d cycles without a transaction",
                     stall_cycles);
            $display("tb_top: FAIL");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_scores.size() == 0) begin
               note_mismatch("result with no set pending", 0, 1);
            end else begin
               want = pending_scores.pop_front();
               sets_scored++;
               if (want.stopped_early) begin
                  early_stops++;
               end
               if (want.set_overflow) begin
                  overflow_sets++;
               end
               if (rsp_min_distance !== want.min_distance) begin
                  note_mismatch("min_distance", want.min_distance, rsp_min_distance);
               end
               if (rsp_distance_sum !== want.distance_sum) begin
                  note_mismatch("distance_sum", want.distance_sum, rsp_distance_sum);
               end
               if (rsp_pairs_examined !== want.pairs_examined) begin
                  note_mismatch("pairs_examined", want.pairs_examined, rsp_pairs_examined);
               end
               if (rsp_stopped_early !== want.stopped_early) begin
                  note_mismatch("stopped_early", want.stopped_early, rsp_stopped_early);
               end
               if (rsp_set_overflow !== want.set_overflow) begin
                  note_mismatch("set_overflow", want.set_overflow, rsp_set_overflow);
               end
            end
         end
      end
   end

   // Presents one key and returns at the edge that accepts it, with start still
   // high, so that a following key can go out on the very next cycle. Whoever
   // stops sending parks the channel through settle().
   task automatic send_key(input bit [KEY_BITS-1:0] key, input bit last);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start        <= 1'b1;
      req_key_high <= key[KEY_BITS-1:HALF_BITS];
      req_key_low  <= key[HALF_BITS-1:0];
      req_last_key <= last;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      take_key(key, last);
      keys_sent++;
   endtask

   // Sends a set of random keys; the final one closes the set.
   task automatic send_set(input int unsigned size);
      cluster_key = {$urandom, $urandom, $urandom, $urandom};
      for (int unsigned k = 0; k < size; k++) begin
         send_key(draw_key(), k == size - 1);
      end
   endtask

   // Drops start, waits until every owed score has come back, then lets the
   // pipeline drain. The block is idle afterwards.
   task automatic settle();
      start        <= 1'b0;
      req_last_key <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the threshold register in a setup and an access cycle, then reads
   // it back the same way. The upper data bits carry noise on the write; the
   // register keeps only its low byte.
   task automatic set_reject_below(input bit [7:0] value);
      bit [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REJECT_BELOW_ADDR;
      pwdata  <= {CSR_DATA_W'($urandom)} & ~CSR_DATA_W'(8'hFF) | CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      stop_threshold = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== CSR_DATA_W'(value)) begin
         note_mismatch("reject_below read-back", value, got);
      end
   endtask

   // The register is taken through its extremes and a mixed bit pattern.
   task automatic test_threshold_register();
      set_reject_below(8'd128);
      set_reject_below(8'hFF);
      set_reject_below(8'h5A);
      set_reject_below(8'h00);
   endtask

   // A set of one key has no pair: the minimum stays at its seed of 128.
   task automatic test_single_key();
      send_key('1, 1'b1);
      settle();
   endtask

   // Distances of 128 and 0 and the two checkerboard patterns, with the walk
   // never stopping so that every pair is summed.
   task automatic test_extreme_distances();
      send_key('0, 1'b0);
      send_key('1, 1'b0);
      send_key({8{16'hAAAA}}, 1'b0);
      send_key({8{16'h5555}}, 1'b0);
      send_key('1, 1'b1);
      settle();
   endtask

   // Early stop. Above 128 the walk halts after the first pair. At 128 a first
   // pair at full distance does not halt it, but the repeat that follows does.
   // At 1 only an exact repeat halts it, here at the end of the second row with
   // the third row still unvisited.
   task automatic test_early_stop();
      bit [KEY_BITS-1:0] a;
      bit [KEY_BITS-1:0] b;
      a = {$urandom, $urandom, $urandom, $urandom};
      b = {$urandom, $urandom, $urandom, $urandom};
      set_reject_below(8'hFF);
      send_key(a, 1'b0);
      send_key(b, 1'b0);
      send_key(~a, 1'b1);
      settle();
      set_reject_below(8'd128);
      send_key('0, 1'b0);
      send_key('1, 1'b0);
      send_key('0, 1'b1);
      settle();
      set_reject_below(8'd1);
      send_key(a, 1'b0);
      send_key(b, 1'b0);
      send_key(~b, 1'b0);
      send_key(b, 1'b1);
      settle();
   endtask

   // Capacity. Two keys past a full store are dropped, the closing one among
   // them, and the walk still covers all 130816 pairs of the keys held. Then a
   // set that fills the store exactly must not be flagged; a high threshold
   // keeps that walk short.
   task automatic test_store_capacity();
      idle_pct = 69;
      set_reject_below(8'h00);
      send_set(KEY_CAP + 2);
      settle();
      idle_pct = 0;
      set_reject_below(8'd200);
      send_set(KEY_CAP);
      settle();
   endtask

   // Random sets, mostly small, in phases that differ in threshold and in how
   // often the input side idles. Each phase starts from an idle block, which
   // also makes the sender wait out every owed score at least once.
   task automatic test_random_sets();
      int unsigned phase_keys;
      int unsigned size_pick;
      int unsigned size;
      bit [7:0]    threshold;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 69;
            default: idle_pct = 8;
         endcase
         case (phase)
            0: threshold = 8'd0;
            1: threshold = 8'($urandom_range(20, 70));
            2: threshold = 8'd128;
            3: threshold = 8'($urandom_range(1, 127));
            4: threshold = 8'($urandom_range(129, 255));
            default: threshold = 8'($urandom_range(1, 20));
         endcase
         set_reject_below(threshold);
         phase_keys = 0;
         while (phase_keys < PHASE_KEYS) begin
            size_pick = $urandom_range(99);
            if (size_pick < 85) begin
               size = $urandom_range(1, 16);
            end else if (size_pick < 98) begin
               size = $urandom_range(17, 48);
            end else begin
               size = $urandom_range(49, 120);
            end
            send_set(size);
            phase_keys += size;
         end
         settle();
      end
   endtask

   initial begin
      held_count     = 0;
      key_dropped    = 1'b0;
      stop_threshold = 8'd0;
      idle_pct       = 0;
      cluster_key    = '0;
      keys_sent      = 0;
      sets_scored    = 0;
      early_stops    = 0;
      overflow_sets  = 0;
      mismatch_count = 0;
      stall_cycles   = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_threshold_register();
      test_single_key();
      test_extreme_distances();
      test_early_stop();
      test_store_capacity();
      test_random_sets();

      settle();
      $display("tb_top: %0d keys sent, %0d sets scored (%0d halted by the threshold,",
               keys_sent, sets_scored, early_stops);
      $display("tb_top: %0d with dropped keys), %0d mismatches",
               overflow_sets, mismatch_count);
      if (mismatch_count == 0 && pending_scores.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
